>>> rtl/mrbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbc_pkg
// Shared widths, constants, item types and helper functions of the read-back
// checker.
// ----------------------------------------------------------------------------
package mrbc_pkg;

  localparam int ADDR_W        = 23;
  localparam int WORD_W        = 32;
  localparam int DIE_COUNT     = 4;
  localparam int DIE_WORD_BITS = 21;
  localparam int DIE_IDX_W     = (DIE_COUNT > 1) ? $clog2(DIE_COUNT) : 1;

  // internal queue, depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [WORD_W-1:0] HASH_MUL_A  = 32'h9E37_79B1;
  localparam logic [WORD_W-1:0] HASH_ADD_A  = 32'h7F4A_7C15;
  localparam logic [WORD_W-1:0] HASH_MUL_B  = 32'h85EB_CA6B;
  localparam logic [WORD_W-1:0] CRC_XOR     = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0] FAILED_WORD = 32'hDEAD_0000;

  // classified item passed from the front to the back
  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [DIE_IDX_W-1:0] die;
    logic [WORD_W-1:0]    exp_word;
    logic [WORD_W-1:0]    actual;   // read data, or the failed-read marker
    logic [WORD_W-1:0]    fed;      // word fed to the CRCs
    logic                 bad;
    logic                 restart;
    logic                 clear_chain;
  } mrbc_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] expected_word;
    logic              mismatch;
    logic [WORD_W-1:0] die_crc_value;
    logic [WORD_W-1:0] chain_crc_value;
    logic [WORD_W-1:0] check_total;
    logic [WORD_W-1:0] fail_total;
    logic [WORD_W-1:0] die_fail_total;
    logic              first_valid;
    logic [ADDR_W-1:0] first_address;
    logic [WORD_W-1:0] first_expected;
    logic [WORD_W-1:0] first_actual;
  } mrbc_result_t;

  // die select from the top address bits, saturating at the last die
  function automatic logic [DIE_IDX_W-1:0] die_of(input logic [ADDR_W-1:0] addr);
    logic [WORD_W-1:0] raw;
    raw = WORD_W'(addr) >> DIE_WORD_BITS;
    if (raw >= WORD_W'(DIE_COUNT)) begin
      return DIE_IDX_W'(DIE_COUNT - 1);
    end
    return DIE_IDX_W'(raw);
  endfunction

  function automatic logic [WORD_W-1:0] crc_next(input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] t;
    t = c ^ v;
    return {t[WORD_W-6:0], t[WORD_W-1:WORD_W-5]} ^ CRC_XOR;
  endfunction

endpackage

>>> rtl/mrbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbc_front
// Accepts read-back words, computes the expected hash word over two multiplier
// stages and classifies each word as pass or fail before queueing it.
// ----------------------------------------------------------------------------
module mrbc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [mrbc_pkg::ADDR_W-1:0] word_address_i,
  input  logic [mrbc_pkg::WORD_W-1:0] read_data_i,
  input  logic                      read_ok_i,
  input  logic                      restart_run_i,
  input  logic                      clear_chain_i,
  input  logic [mrbc_pkg::FIFO_CNT_W-1:0] fifo_count_i,
  output logic                      wr_valid_o,
  output mrbc_pkg::mrbc_item_t      wr_item_o
);
  import mrbc_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic              ok;
    logic              restart;
    logic              clear_chain;
  } front_meta_t;

  logic              v1_q, v1_d, v2_q, v2_d;
  front_meta_t       m1_q, m2_q;
  logic [WORD_W-1:0] x1_q, x1_d, x2_q, x2_d;
  logic [WORD_W-1:0] x1_mix, exp_word;
  logic [FIFO_CNT_W+1:0] pending;
  logic              take;

  // accept only when a queue slot is certain for everything in flight
  assign pending = (FIFO_CNT_W+2)'(fifo_count_i) + (FIFO_CNT_W+2)'(v1_q)
                 + (FIFO_CNT_W+2)'(v2_q);
  assign full = (pending >= (FIFO_CNT_W+2)'(FIFO_DEPTH));
  assign take = push && !full;

  assign x1_d   = WORD_W'(word_address_i) * HASH_MUL_A + HASH_ADD_A;
  assign x1_mix = x1_q ^ (x1_q >> 15);
  assign x2_d   = x1_mix * HASH_MUL_B;
  assign v1_d   = take;
  assign v2_d   = v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d;
    x2_q <= x2_d;
    m1_q <= '{addr: word_address_i, data: read_data_i, ok: read_ok_i,
              restart: restart_run_i, clear_chain: clear_chain_i};
    m2_q <= m1_q;
  end

  assign exp_word = x2_q ^ (x2_q >> 13);

  always_comb begin
    wr_item_o.addr        = m2_q.addr;
    wr_item_o.die         = die_of(m2_q.addr);
    wr_item_o.exp_word    = exp_word;
    wr_item_o.actual      = m2_q.ok ? m2_q.data : FAILED_WORD;
    wr_item_o.fed         = m2_q.ok ? m2_q.data : '0;
    wr_item_o.bad         = !m2_q.ok || (m2_q.data != exp_word);
    wr_item_o.restart     = m2_q.restart;
    wr_item_o.clear_chain = m2_q.clear_chain;
  end

  assign wr_valid_o = v2_q;

endmodule

>>> rtl/mrbc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbc_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mrbc_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_valid_i,
  input  mrbc_pkg::mrbc_item_t       wr_item_i,
  output logic                       rd_valid_o,
  input  logic                       rd_ready_i,
  output mrbc_pkg::mrbc_item_t       rd_item_o,
  output logic [mrbc_pkg::FIFO_CNT_W-1:0] count_o
);
  import mrbc_pkg::*;

  mrbc_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_rd;

  // the front never writes into a full queue
  assign do_rd      = rd_ready_i && (cnt_q != '0);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign count_o    = cnt_q;

  assign wr_ptr_d = wr_valid_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
  assign rd_ptr_d = do_rd ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
  assign cnt_d    = cnt_q + FIFO_CNT_W'(wr_valid_i) - FIFO_CNT_W'(do_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

>>> rtl/mrbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrbc_back
// Applies classified items to the run counters, the die and chain CRCs and the
// first-failure capture, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module mrbc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_valid_i,
  output logic                   rd_ready_o,
  input  mrbc_pkg::mrbc_item_t   rd_item_i,
  output logic                   empty,
  input  logic                   pop,
  output mrbc_pkg::mrbc_result_t result_o
);
  import mrbc_pkg::*;

  logic [WORD_W-1:0] die_crc_q [DIE_COUNT];
  logic [WORD_W-1:0] die_crc_d [DIE_COUNT];
  logic [WORD_W-1:0] die_fail_q [DIE_COUNT];
  logic [WORD_W-1:0] die_fail_d [DIE_COUNT];
  logic [WORD_W-1:0] chain_q, chain_d, check_q, check_d, fail_q, fail_d;
  logic              first_v_q, first_v_d;
  logic [ADDR_W-1:0] first_addr_q, first_addr_d;
  logic [WORD_W-1:0] first_exp_q, first_exp_d, first_act_q, first_act_d;
  logic              out_v_q, out_v_d;
  mrbc_result_t      res_q, res_d;
  logic              take;
  logic [WORD_W-1:0] die_crc_new, die_fail_new, die_crc_base, die_fail_base;
  mrbc_item_t        it;

  assign it         = rd_item_i;
  assign rd_ready_o = !out_v_q || pop;
  assign take       = rd_valid_i && rd_ready_o;
  assign empty      = !out_v_q;
  assign result_o   = res_q;

  always_comb begin
    // restart wipes the run state before the item lands
    die_crc_base  = it.restart ? '0 : die_crc_q[it.die];
    die_fail_base = it.restart ? '0 : die_fail_q[it.die];
    die_crc_new   = crc_next(die_crc_base, it.fed);
    die_fail_new  = die_fail_base + WORD_W'(it.bad);

    chain_d = crc_next(it.clear_chain ? '0 : chain_q, it.fed);
    check_d = (it.restart ? '0 : check_q) + WORD_W'(1);
    fail_d  = (it.restart ? '0 : fail_q) + WORD_W'(it.bad);

    first_v_d    = it.restart ? 1'b0 : first_v_q;
    first_addr_d = it.restart ? '0 : first_addr_q;
    first_exp_d  = it.restart ? '0 : first_exp_q;
    first_act_d  = it.restart ? '0 : first_act_q;
    if (it.bad && !first_v_d) begin
      first_v_d    = 1'b1;
      first_addr_d = it.addr;
      first_exp_d  = it.exp_word;
      first_act_d  = it.actual;
    end

    for (int i = 0; i < DIE_COUNT; i++) begin
      if (it.die == DIE_IDX_W'(i)) begin
        die_crc_d[i]  = die_crc_new;
        die_fail_d[i] = die_fail_new;
      end else begin
        die_crc_d[i]  = it.restart ? '0 : die_crc_q[i];
        die_fail_d[i] = it.restart ? '0 : die_fail_q[i];
      end
    end

    res_d.expected_word   = it.exp_word;
    res_d.mismatch        = it.bad;
    res_d.die_crc_value   = die_crc_new;
    res_d.chain_crc_value = chain_d;
    res_d.check_total     = check_d;
    res_d.fail_total      = fail_d;
    res_d.die_fail_total  = die_fail_new;
    res_d.first_valid     = first_v_d;
    res_d.first_address   = first_addr_d;
    res_d.first_expected  = first_exp_d;
    res_d.first_actual    = first_act_d;

    out_v_d = take || (out_v_q && !pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIE_COUNT; i++) begin
        die_crc_q[i]  <= '0;
        die_fail_q[i] <= '0;
      end
      chain_q      <= '0;
      check_q      <= '0;
      fail_q       <= '0;
      first_v_q    <= 1'b0;
      first_addr_q <= '0;
      first_exp_q  <= '0;
      first_act_q  <= '0;
      out_v_q      <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (take) begin
        for (int i = 0; i < DIE_COUNT; i++) begin
          die_crc_q[i]  <= die_crc_d[i];
          die_fail_q[i] <= die_fail_d[i];
        end
        chain_q      <= chain_d;
        check_q      <= check_d;
        fail_q       <= fail_d;
        first_v_q    <= first_v_d;
        first_addr_q <= first_addr_d;
        first_exp_q  <= first_exp_d;
        first_act_q  <= first_act_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

>>> rtl/memory_test_readback_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_test_readback_checker_top
// Read-back checker for a memory filled with an address hash pattern.
// ----------------------------------------------------------------------------
// One word is taken per cycle, sustained while results are popped, and one
// result per word is queued in order. A result passes from its transfer
// through the first multiplier stage of the hash, the second stage, the
// internal queue and the back-end result register. The rate is set by the
// back end, which updates counters, die and chain CRCs and the first-failure
// capture once per cycle while its result register is free or popped; full
// rises only when the four-entry internal queue plus the hash stages could
// overflow, i.e. while results are not being popped.
// ----------------------------------------------------------------------------
module memory_test_readback_checker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [mrbc_pkg::ADDR_W-1:0] word_address_i,
  input  logic [mrbc_pkg::WORD_W-1:0] read_data_i,
  input  logic                        read_ok_i,
  input  logic                        restart_run_i,
  input  logic                        clear_chain_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [mrbc_pkg::WORD_W-1:0] expected_word_o,
  output logic                        mismatch_o,
  output logic [mrbc_pkg::WORD_W-1:0] die_crc_value_o,
  output logic [mrbc_pkg::WORD_W-1:0] chain_crc_value_o,
  output logic [mrbc_pkg::WORD_W-1:0] check_total_o,
  output logic [mrbc_pkg::WORD_W-1:0] fail_total_o,
  output logic [mrbc_pkg::WORD_W-1:0] die_fail_total_o,
  output logic                        first_valid_o,
  output logic [mrbc_pkg::ADDR_W-1:0] first_address_o,
  output logic [mrbc_pkg::WORD_W-1:0] first_expected_o,
  output logic [mrbc_pkg::WORD_W-1:0] first_actual_o
);
  import mrbc_pkg::*;

  logic                  wr_valid, rd_valid, rd_ready;
  mrbc_item_t            wr_item, rd_item;
  logic [FIFO_CNT_W-1:0] fifo_count;
  mrbc_result_t          res;

  mrbc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .word_address_i (word_address_i),
    .read_data_i    (read_data_i),
    .read_ok_i      (read_ok_i),
    .restart_run_i  (restart_run_i),
    .clear_chain_i  (clear_chain_i),
    .fifo_count_i   (fifo_count),
    .wr_valid_o     (wr_valid),
    .wr_item_o      (wr_item)
  );

  mrbc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_item_i  (wr_item),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_item_o  (rd_item),
    .count_o    (fifo_count)
  );

  mrbc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (rd_valid),
    .rd_ready_o (rd_ready),
    .rd_item_i  (rd_item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (res)
  );

  assign expected_word_o   = res.expected_word;
  assign mismatch_o        = res.mismatch;
  assign die_crc_value_o   = res.die_crc_value;
  assign chain_crc_value_o = res.chain_crc_value;
  assign check_total_o     = res.check_total;
  assign fail_total_o      = res.fail_total;
  assign die_fail_total_o  = res.die_fail_total;
  assign first_valid_o     = res.first_valid;
  assign first_address_o   = res.first_address;
  assign first_expected_o  = res.first_expected;
  assign first_actual_o    = res.first_actual;

endmodule
